// ===== rtl/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg
// shared types and constants of the polyline point densifier
// ----------------------------------------------------------------------------
package ppd_pkg;

    localparam int CoordW     = 32;
    localparam int LevelW     = 16;
    localparam int SpacingW   = 31;
    localparam int MaxInserts = 63;
    localparam logic [SpacingW-1:0] SpacingReset = 31'd65536;

    localparam int MagW  = 33;
    localparam int SqW   = 68;
    localparam int RootW = 35;
    localparam int DenW  = 36;
    localparam int NumW  = 72;

    localparam int CfgAddrW = 1;
    localparam logic [CfgAddrW-1:0] RegMinSpacing = 1'b0;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] z;
        logic [LevelW-1:0] level;
        logic              starts_line;
    } point_t;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] z;
        logic [LevelW-1:0] level;
        logic              is_inserted;
        logic              truncated;
        logic              last_of_run;
    } result_t;

    // job handed from front to back: previous point, new point, mode
    typedef struct packed {
        point_t prev;
        point_t cur;
        logic   pass;
    } job_t;

endpackage

// ===== rtl/ppd_if.sv =====
// ----------------------------------------------------------------------------
// ppd_in_if / ppd_out_if
// valid/ready channels carrying points and results
// ----------------------------------------------------------------------------
interface ppd_in_if
    import ppd_pkg::*;
();
    logic   valid;
    logic   ready;
    point_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ppd_out_if
    import ppd_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ppd_front.sv =====
// ----------------------------------------------------------------------------
// ppd_front
// accepts points, tracks the previous point and queues segment jobs
// ----------------------------------------------------------------------------
module ppd_front
    import ppd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  point_t in_data,
    output logic   job_valid,
    input  logic   job_ready,
    output job_t   job_data
);

    job_t   q_reg [2];
    logic   wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    point_t prev_reg;
    logic   have_reg;
    logic   push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job_data  = q_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            cnt_reg  <= 2'd0;
            have_reg <= 1'b0;
            prev_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                q_reg[wp_reg].prev <= prev_reg;
                q_reg[wp_reg].cur  <= in_data;
                q_reg[wp_reg].pass <= !have_reg || in_data.starts_line;
                wp_reg   <= !wp_reg;
                prev_reg <= in_data;
                have_reg <= 1'b1;
            end
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/ppd_back.sv =====
// ----------------------------------------------------------------------------
// ppd_back
// computes distance, root and ratio per segment and emits the points
// ----------------------------------------------------------------------------
module ppd_back
    import ppd_pkg::*;
#(
    parameter int MAX_INSERTS = MaxInserts
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SpacingW-1:0] min_spacing,
    input  logic                job_valid,
    output logic                job_ready,
    input  job_t                job_data,
    output logic                out_valid,
    input  logic                out_ready,
    output result_t             out_data
);

    localparam int CntW = $clog2(MAX_INSERTS + 1) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_CMP, S_ROOT, S_KDIV, S_SETUP, S_MUL, S_DIV, S_EMIT, S_LAST
    } state_t;

    state_t state_reg;
    job_t   job_reg;
    logic [MagW-1:0]   mag_reg [4];
    logic              neg_reg [4];
    logic [SqW-1:0]    sum_reg;
    logic [1:0]        ax_reg;
    logic [RootW-1:0]  root_reg;
    logic [6:0]        bit_reg;
    logic [SpacingW-1:0] s_reg;
    logic [RootW-1:0]  kq_reg;
    logic [DenW-1:0]   krem_reg;
    logic [DenW-1:0]   den_reg;
    logic [CntW-1:0]   k_reg, n_reg;
    logic              trunc_reg;
    logic [NumW-1:0]   mnum_reg;
    logic [DenW-1:0]   rem_reg;
    logic [NumW-1:0]   q_reg;
    logic [CoordW-1:0] res_reg [3];
    logic [NumW-1:0]   acc_reg [4];
    logic              ov_reg;
    result_t           out_reg;

    logic [SqW+1:0]    tsq;
    logic [RootW-1:0]  tcand;
    logic [DenW:0]     rsh;
    logic [DenW:0]     ksh;
    logic [2*MagW-1:0] sq_prod;
    logic [MagW+SpacingW-1:0] step_prod;
    logic [NumW-1:0]   acc_sum;
    logic              emit_load;

    assign job_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    assign tcand = root_reg | (RootW'(1) << bit_reg[5:0]);
    assign tsq   = (SqW+2)'(tcand) * (SqW+2)'(tcand);
    assign rsh   = {rem_reg, mnum_reg[NumW-1]};
    assign ksh   = {krem_reg, root_reg[RootW-1]};

    assign sq_prod   = (2*MagW)'(mag_reg[ax_reg]) * (2*MagW)'(mag_reg[ax_reg]);
    assign step_prod = (MagW+SpacingW)'(mag_reg[ax_reg]) * (MagW+SpacingW)'(s_reg);
    assign acc_sum   = acc_reg[ax_reg] + NumW'(step_prod);

    assign emit_load = (((state_reg == S_EMIT) && (ax_reg == 2'd3)) || (state_reg == S_LAST))
                       && (!ov_reg || out_ready);

    function automatic logic [MagW-1:0] absd(input logic [CoordW-1:0] a,
                                             input logic [CoordW-1:0] b);
        logic signed [MagW-1:0] d;
        d = $signed({b[CoordW-1], b}) - $signed({a[CoordW-1], a});
        return d[MagW-1] ? MagW'(-d) : MagW'(d);
    endfunction

    function automatic logic [CoordW-1:0] sel_prev(input job_t j, input logic [1:0] i);
        case (i)
            2'd0: return j.prev.x;
            2'd1: return j.prev.y;
            2'd2: return j.prev.z;
            default: return {{(CoordW-LevelW){1'b0}}, j.prev.level};
        endcase
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (emit_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid && !ov_reg)
                    begin
                        job_reg   <= job_data;
                        s_reg     <= (min_spacing == '0) ? SpacingW'(1) : min_spacing;
                        trunc_reg <= 1'b0;
                        mag_reg[0] <= absd(job_data.prev.x, job_data.cur.x);
                        mag_reg[1] <= absd(job_data.prev.y, job_data.cur.y);
                        mag_reg[2] <= absd(job_data.prev.z, job_data.cur.z);
                        mag_reg[3] <= absd({16'd0, job_data.prev.level},
                                           {16'd0, job_data.cur.level});
                        neg_reg[0] <= $signed(job_data.cur.x) < $signed(job_data.prev.x);
                        neg_reg[1] <= $signed(job_data.cur.y) < $signed(job_data.prev.y);
                        neg_reg[2] <= $signed(job_data.cur.z) < $signed(job_data.prev.z);
                        neg_reg[3] <= job_data.cur.level < job_data.prev.level;
                        sum_reg   <= '0;
                        ax_reg    <= 2'd0;
                        state_reg <= job_data.pass ? S_LAST : S_SQ;
                    end
                end
                S_SQ:
                begin
                    sum_reg <= sum_reg + SqW'(sq_prod);
                    ax_reg  <= ax_reg + 2'd1;
                    if (ax_reg == 2'd2)
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    root_reg <= '0;
                    bit_reg  <= 7'(RootW - 1);
                    if (sum_reg > SqW'((2*SpacingW)'(s_reg) * (2*SpacingW)'(s_reg)))
                        state_reg <= S_ROOT;
                    else
                        state_reg <= S_LAST;
                end
                S_ROOT:
                begin
                    if (tsq <= (SqW+2)'(sum_reg))
                        root_reg <= tcand;
                    if (bit_reg == 7'd0)
                    begin
                        state_reg <= S_KDIV;
                        bit_reg   <= 7'(RootW - 1);
                        krem_reg  <= '0;
                        kq_reg    <= '0;
                    end
                    else
                        bit_reg <= bit_reg - 7'd1;
                end
                S_KDIV:
                begin
                    // restoring divide d / s, shifting d through root_reg
                    root_reg <= {root_reg[RootW-2:0], root_reg[RootW-1]};
                    if (ksh >= (DenW+1)'(s_reg))
                    begin
                        krem_reg <= DenW'(ksh - (DenW+1)'(s_reg));
                        kq_reg   <= {kq_reg[RootW-2:0], 1'b1};
                    end
                    else
                    begin
                        krem_reg <= DenW'(ksh);
                        kq_reg   <= {kq_reg[RootW-2:0], 1'b0};
                    end
                    if (bit_reg == 7'd0)
                        state_reg <= S_SETUP;
                    else
                        bit_reg <= bit_reg - 7'd1;
                end
                S_SETUP:
                begin
                    den_reg <= DenW'(root_reg) + DenW'(s_reg);
                    if (kq_reg >= RootW'(MAX_INSERTS))
                    begin
                        k_reg     <= CntW'(MAX_INSERTS);
                        trunc_reg <= 1'b1;
                    end
                    else
                        k_reg <= CntW'(kq_reg) + CntW'(1);
                    n_reg      <= CntW'(1);
                    acc_reg[0] <= '0;
                    acc_reg[1] <= '0;
                    acc_reg[2] <= '0;
                    acc_reg[3] <= '0;
                    ax_reg     <= 2'd0;
                    state_reg  <= S_MUL;
                end
                S_MUL:
                begin
                    // running sum of n * s * |delta| per field
                    mnum_reg        <= acc_sum;
                    acc_reg[ax_reg] <= acc_sum;
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    bit_reg   <= 7'(NumW - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    mnum_reg <= {mnum_reg[NumW-2:0], 1'b0};
                    if (rsh >= {1'b0, den_reg})
                    begin
                        rem_reg <= DenW'(rsh - {1'b0, den_reg});
                        q_reg   <= {q_reg[NumW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= DenW'(rsh);
                        q_reg   <= {q_reg[NumW-2:0], 1'b0};
                    end
                    if (bit_reg == 7'd0)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                        bit_reg <= bit_reg - 7'd1;
                end
                S_EMIT:
                begin
                    if (ax_reg != 2'd3)
                    begin
                        res_reg[ax_reg] <= neg_reg[ax_reg]
                            ? sel_prev(job_reg, ax_reg) - CoordW'(q_reg)
                            : sel_prev(job_reg, ax_reg) + CoordW'(q_reg);
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                    else if (emit_load)
                    begin
                        out_reg.x <= res_reg[0];
                        out_reg.y <= res_reg[1];
                        out_reg.z <= res_reg[2];
                        out_reg.level <= neg_reg[3]
                            ? LevelW'(job_reg.prev.level - LevelW'(q_reg))
                            : LevelW'(job_reg.prev.level + LevelW'(q_reg));
                        out_reg.is_inserted <= 1'b1;
                        out_reg.truncated   <= trunc_reg;
                        out_reg.last_of_run <= 1'b0;
                        ax_reg <= 2'd0;
                        if (n_reg == k_reg)
                            state_reg <= S_LAST;
                        else
                        begin
                            n_reg     <= n_reg + CntW'(1);
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_LAST:
                begin
                    if (emit_load)
                    begin
                        out_reg.x <= job_reg.cur.x;
                        out_reg.y <= job_reg.cur.y;
                        out_reg.z <= job_reg.cur.z;
                        out_reg.level <= job_reg.cur.level;
                        out_reg.is_inserted <= 1'b0;
                        out_reg.truncated   <= trunc_reg;
                        out_reg.last_of_run <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/polyline_point_densifier_core.sv =====
// a pass-through point goes from the job queue to the output register; a densified segment
// first takes the squared distance, the square root and the insert count d / s, then each
// inserted point runs one bit-serial 72-step divide per field through the shared divider
// the back end works on one segment at a time
// a two-entry job queue lets the input side keep accepting while a segment runs
// reset: asynchronous, clears previous point and sets min_spacing to 1.0
// ----------------------------------------------------------------------------
// polyline_point_densifier_core
// linear densification of a polyline point stream
// ----------------------------------------------------------------------------
module polyline_point_densifier_core
    import ppd_pkg::*;
#(
    parameter int MAX_INSERTS = MaxInserts
)
(
    input  logic                clk,
    input  logic                rst_n,
    ppd_in_if.sink              in_ch,
    ppd_out_if.source           out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW+1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [SpacingW-1:0] spacing_reg;
    logic job_valid, job_ready;
    job_t job_data;

    assign pready = 1'b1;
    assign prdata = (paddr[CfgAddrW+1:2] == RegMinSpacing) ? {1'b0, spacing_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spacing_reg <= SpacingReset;
        else if (psel && penable && pwrite && paddr[CfgAddrW+1:2] == RegMinSpacing)
            spacing_reg <= pwdata[SpacingW-1:0];
    end

    ppd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (in_ch.data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_data  (job_data)
    );

    ppd_back #(.MAX_INSERTS(MAX_INSERTS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .min_spacing (spacing_reg),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job_data    (job_data),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_data    (out_ch.data)
    );

endmodule

// ===== sim/polyline_point_densifier_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyline_point_densifier_core_test
// Drives polyline points into the densifier and checks every emitted point
// against a predictor of the interpolation, at several spacings, with random
// gaps on the point side and random stalls on the result side.
// ----------------------------------------------------------------------------
module polyline_point_densifier_core_test;
    import ppd_pkg::*;

    localparam int WatchdogLimit = 60000;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CfgAddrW+1:0] paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    ppd_in_if  in_ch ();
    ppd_out_if out_ch ();

    polyline_point_densifier_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    point_t          last_point;
    logic            have_last;
    logic [30:0]     spacing;
    result_t         pending_points[$];

    int              mismatches;
    int              gap_pct;
    int              stall_pct;
    int              hold_cycles;
    int              quiet_cycles;

    initial begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic logic [127:0] isqrt(logic [127:0] s);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int b = 34; b >= 0; b--)
        begin
            t = r | (128'd1 << b);
            if (t * t <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [31:0] lerp_field(longint a, longint b, logic [127:0] m,
                                               logic [127:0] den);
        longint       d;
        logic [127:0] mag;
        logic [127:0] q;
        longint       v;
        d = b - a;
        mag = (d < 0) ? 128'(-d) : 128'(d);
        q = (mag * m) / den;
        v = (d < 0) ? a - longint'(q[63:0]) : a + longint'(q[63:0]);
        return v[31:0];
    endfunction

    function automatic logic [127:0] sq_diff(longint a, longint b);
        longint       d;
        logic [127:0] mag;
        d = b - a;
        mag = (d < 0) ? 128'(-d) : 128'(d);
        return mag * mag;
    endfunction

    // works out the points emitted for one accepted input point
    task automatic densify_point(point_t p);
        result_t      run[$];
        result_t      r;
        longint       px, py, pz, pl, nx, ny, nz, nl;
        logic [127:0] s, sum, d, k, den;
        logic         trunc;
        trunc = 1'b0;
        px = $signed(last_point.x);
        py = $signed(last_point.y);
        pz = $signed(last_point.z);
        pl = last_point.level;
        nx = $signed(p.x);
        ny = $signed(p.y);
        nz = $signed(p.z);
        nl = p.level;
        if (have_last && !p.starts_line)
        begin
            s = (spacing == 0) ? 128'd1 : 128'(spacing);
            sum = sq_diff(px, nx) + sq_diff(py, ny) + sq_diff(pz, nz);
            if (sum > s * s)
            begin
                d = isqrt(sum);
                k = d / s + 1;
                den = d + s;
                if (k > MaxInserts)
                begin
                    k = MaxInserts;
                    trunc = 1'b1;
                end
                for (int n = 1; n <= int'(k); n++)
                begin
                    r.x = lerp_field(px, nx, n * s, den);
                    r.y = lerp_field(py, ny, n * s, den);
                    r.z = lerp_field(pz, nz, n * s, den);
                    r.level = 16'(lerp_field(pl, nl, n * s, den));
                    r.is_inserted = 1'b1;
                    r.truncated = trunc;
                    r.last_of_run = 1'b0;
                    run = {run, r};
                end
            end
        end
        r.x = p.x;
        r.y = p.y;
        r.z = p.z;
        r.level = p.level;
        r.is_inserted = 1'b0;
        r.truncated = trunc;
        r.last_of_run = 1'b1;
        run = {run, r};
        foreach (run[i])
            pending_points = {pending_points, run[i]};
        last_point = p;
        have_last = 1'b1;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    // result side: random stalls, long hold-off on request, and checking
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_points.size() == 0)
                    report_mismatch("unexpected transfer", out_ch.data.x, 32'h0);
                else
                begin
                    result_t want;
                    want = pending_points.pop_front();
                    if (out_ch.data.x !== want.x)
                        report_mismatch("x", out_ch.data.x, want.x);
                    if (out_ch.data.y !== want.y)
                        report_mismatch("y", out_ch.data.y, want.y);
                    if (out_ch.data.z !== want.z)
                        report_mismatch("z", out_ch.data.z, want.z);
                    if (out_ch.data.level !== want.level)
                        report_mismatch("level", out_ch.data.level, want.level);
                    if (out_ch.data.is_inserted !== want.is_inserted)
                        report_mismatch("is_inserted", out_ch.data.is_inserted,
                                        want.is_inserted);
                    if (out_ch.data.truncated !== want.truncated)
                        report_mismatch("truncated", out_ch.data.truncated, want.truncated);
                    if (out_ch.data.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", out_ch.data.last_of_run,
                                        want.last_of_run);
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("polyline_point_densifier_core verification failed");
            $finish;
        end
    end

    task automatic send_point(point_t p);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < gap_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= p;
        do
            @(posedge clk);
        while (!in_ch.ready);
        densify_point(p);
    endtask

    task automatic send_xyz(longint x, longint y, longint z, int lv, bit sl);
        point_t p;
        p.x = x[31:0];
        p.y = y[31:0];
        p.z = z[31:0];
        p.level = lv[15:0];
        p.starts_line = sl;
        send_point(p);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_spacing(logic [30:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {RegMinSpacing, 2'b00};
        pwdata <= {1'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        spacing = value;
    endtask

    task automatic test_directed_default_spacing();
        longint s;
        s = 65536;
        send_xyz(0, 0, 0, 0, 1'b0);
        send_xyz(2 * s, 0, 0, 65535, 1'b0);
        send_xyz(2 * s, 0, 0, 65535, 1'b0);
        send_xyz(2 * s, s, 0, 0, 1'b0);
        send_xyz(-5 * s, 7 * s, -3 * s, 1234, 1'b1);
        send_xyz(-5 * s + 3 * s, 7 * s - s, -3 * s + 2 * s, 0, 1'b0);
        send_xyz(95 * s, 7 * s, -3 * s, 65535, 1'b0);
        send_xyz(95 * s - 17, 7 * s + 1, -3 * s - 40000, 0, 1'b0);
        wait_drained();
    endtask

    task automatic test_directed_spacing_extremes();
        longint lo, hi;
        lo = -2147483648;
        hi = 2147483647;
        write_spacing(31'h7FFF_FFFF);
        send_xyz(lo, lo, lo, 0, 1'b1);
        send_xyz(hi, hi, hi, 65535, 1'b0);
        send_xyz(lo, hi, lo, 0, 1'b0);
        send_xyz(hi, 0, 0, 32768, 1'b0);
        wait_drained();
        write_spacing(31'd1);
        send_xyz(100, 100, 100, 10, 1'b1);
        send_xyz(101, 100, 100, 20, 1'b0);
        send_xyz(104, 100, 100, 65535, 1'b0);
        send_xyz(101, 98, 99, 0, 1'b0);
        wait_drained();
        write_spacing(31'd0);
        send_xyz(-1, -1, -1, 65535, 1'b0);
        send_xyz(1, -1, -1, 0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_stream(int count);
        longint span, x, y, z;
        int     pick;
        for (int i = 0; i < count; i++)
        begin
            span = (spacing == 0) ? 1 : longint'(spacing);
            pick = $urandom_range(0, 99);
            if (pick < 8 || !have_last)
                send_xyz($urandom, $urandom, $urandom, $urandom_range(0, 65535), 1'b1);
            else if (pick < 10)
                send_xyz($urandom, $urandom, $urandom, $urandom_range(0, 65535),
                         $urandom_range(0, 1));
            else
            begin
                x = longint'($signed(last_point.x))
                    + (longint'($urandom_range(0, 2000)) - 1000) * span / 600;
                y = longint'($signed(last_point.y))
                    + (longint'($urandom_range(0, 2000)) - 1000) * span / 600;
                z = longint'($signed(last_point.z))
                    + (longint'($urandom_range(0, 2000)) - 1000) * span / 600;
                send_xyz(x, y, z, $urandom_range(0, 65535), 1'b0);
            end
        end
        wait_drained();
    endtask

    task automatic test_random_idling();
        gap_pct = 10;
        stall_pct = 80;
        write_spacing(31'd65536);
        test_random_stream(150);
        gap_pct = 80;
        stall_pct = 10;
        write_spacing(31'($urandom_range(1, 32'h7FFF_FFFF)));
        test_random_stream(150);
        gap_pct = 0;
        stall_pct = 0;
        write_spacing(31'd300);
        test_random_stream(130);
    endtask

    task automatic test_result_backpressure();
        gap_pct = 0;
        stall_pct = 0;
        write_spacing(31'd65536);
        hold_cycles = 3000;
        test_random_stream(20);
    endtask

    initial begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        mismatches = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        last_point = '0;
        have_last = 1'b0;
        spacing = SpacingReset;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_default_spacing();
        test_directed_spacing_extremes();
        test_random_idling();
        test_result_backpressure();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_points.size() == 0)
            $display("polyline_point_densifier_core verification clean");
        else
            $display("polyline_point_densifier_core verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ppd_pkg.sv
rtl/ppd_if.sv
rtl/ppd_front.sv
rtl/ppd_back.sv
rtl/polyline_point_densifier_core.sv
sim/polyline_point_densifier_core_test.sv
